// ----- hdl/mb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mb_pkg
// Shared constants, controller states and the command/status bundles that
// connect the escape-time controller and its datapath.
// ----------------------------------------------------------------------------
package mb_pkg;

    localparam int FRAC_BITS     = 28;
    localparam int ITER_BITS     = 16;
    localparam int PERIOD_WINDOW = 21;
    localparam int EXTRA_STEPS   = 4;

    localparam int C_W   = 32;              // point coordinate, Q4.28
    localparam int Z_W   = 64;              // wide z for the extra steps
    localparam int EXT_W = ITER_BITS + 1;
    localparam int MAG_W = 32;
    localparam int MAG_FRAC = 16;           // magnitude is Q16.16

    localparam int PER_W  = (PERIOD_WINDOW > 1) ? $clog2(PERIOD_WINDOW) : 1;
    localparam int XCNT_W = (EXTRA_STEPS > 1) ? $clog2(EXTRA_STEPS) : 1;

    localparam logic [ITER_BITS-1:0] MAX_ITER_RESET = ITER_BITS'(256);
    localparam logic [Z_W-1:0]       ESCAPE_LIMIT   = Z_W'(4) << (2 * FRAC_BITS);
    localparam logic [EXT_W-1:0]     EXTRA_INC      = EXT_W'(EXTRA_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IT_MUL,
        ST_IT_UPD,
        ST_X_MUL,
        ST_X_WAIT,
        ST_X_SUM1,
        ST_X_SUM2,
        ST_M_SUM,
        ST_M_MAG,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_IT_MUL,
        OP_IT_UPD,
        OP_X_SUM1,
        OP_X_SUM2,
        OP_M_SUM,
        OP_M_MAG,
        OP_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        SEL_RR,
        SEL_II,
        SEL_RI
    } mul_sel_t;

    typedef struct packed {
        dp_op_t   op;
        logic     mul_start;
        mul_sel_t mul_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic count_at_max;
        logic escape;
        logic periodic;
        logic mul_done;
    } dp_sts_t;

endpackage
`default_nettype wire

// ----- hdl/mandelbrot_escape_time.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Steps: load, multiply/update steps until the limit, escape or a periodic
//   match; an escaping point then adds 4 wide steps and a magnitude step.
// Throughput: one point at a time; each iteration step is a registered
//   32x32 product stage, then update; wide steps share one 32x32 unit.
// Reset: synchronous active-low; idle, no result pending, max_iterations 256.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [mb_pkg::C_W-1:0]      s_c_real,
    input  logic signed [mb_pkg::C_W-1:0]      s_c_imag,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mb_pkg::ITER_BITS-1:0]       m_iteration_count,
    output logic [mb_pkg::EXT_W-1:0]           m_extended_count,
    output logic                               m_escaped,
    output logic [mb_pkg::MAG_W-1:0]           m_final_magnitude,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mb_pkg::ITER_BITS-1:0]       cfg_data
);
    import mb_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // limit register takes a beat every cycle
    assign cfg_ready = 1'b1;

    mb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mb_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_c_real          (s_c_real),
        .s_c_imag          (s_c_imag),
        .cfg_valid         (cfg_valid),
        .cfg_data          (cfg_data),
        .m_iteration_count (m_iteration_count),
        .m_extended_count  (m_extended_count),
        .m_escaped         (m_escaped),
        .m_final_magnitude (m_final_magnitude)
    );

endmodule
`default_nettype wire

// ----- hdl/mb_mul64.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mb_mul64
// Iterative signed 64x64 fixed-point multiply: (a*b) >> FRAC_BITS rounded
// toward minus infinity, saturated to 64 bits. One 32x32 multiplier, four
// partial products, then round and saturate.
// ----------------------------------------------------------------------------
module mb_mul64 (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic signed [mb_pkg::Z_W-1:0]  a,
    input  logic signed [mb_pkg::Z_W-1:0]  b,
    output logic                           done,
    output logic signed [mb_pkg::Z_W-1:0]  y
);
    import mb_pkg::*;

    localparam int H_W = Z_W / 2;
    localparam int P_W = 2 * Z_W;
    localparam int Q_W = P_W - FRAC_BITS;

    localparam logic [2:0] PH_LAST_PROD = 3'd3;
    localparam logic [2:0] PH_FIRST_ACC = 3'd1;
    localparam logic [2:0] PH_LAST_ACC  = 3'd4;
    localparam logic [2:0] PH_ROUND     = 3'd5;
    localparam logic [2:0] PH_SAT       = 3'd6;

    localparam logic signed [Z_W-1:0] S_MAX = {1'b0, {(Z_W-1){1'b1}}};
    localparam logic signed [Z_W-1:0] S_MIN = {1'b1, {(Z_W-1){1'b0}}};

    logic                  busy_reg, busy_next;
    logic [2:0]            phase_reg, phase_next;
    logic                  done_reg, done_next;

    logic [Z_W-1:0]        ua_reg, ub_reg;
    logic                  neg_reg;
    logic [Z_W-1:0]        prod_reg;
    logic [1:0]            prod_sel_reg;
    logic [P_W-1:0]        acc_reg;
    logic [Q_W-1:0]        q_reg;
    logic signed [Z_W-1:0] y_reg;

    logic [H_W-1:0]        pa, pb;
    logic [Z_W-1:0]        prod_w;
    logic [P_W-1:0]        addend;
    logic                  round_up;
    logic                  q_over;
    logic signed [Z_W-1:0] sat_w;

    // piece order: lo*lo, lo*hi, hi*lo, hi*hi
    always_comb begin
        pa = phase_reg[1] ? ua_reg[Z_W-1:H_W] : ua_reg[H_W-1:0];
        pb = phase_reg[0] ? ub_reg[Z_W-1:H_W] : ub_reg[H_W-1:0];
    end

    assign prod_w = pa * pb;

    always_comb begin
        addend = P_W'(prod_reg);
        if (prod_sel_reg[0]) begin
            addend = addend << H_W;
        end
        if (prod_sel_reg[1]) begin
            addend = addend << H_W;
        end
    end

    assign round_up = neg_reg && (|acc_reg[FRAC_BITS-1:0]);
    assign q_over   = |q_reg[Q_W-1:Z_W-1];

    always_comb begin
        if (neg_reg) begin
            sat_w = q_over ? S_MIN : -$signed(q_reg[Z_W-1:0]);
        end else begin
            sat_w = q_over ? S_MAX : $signed(q_reg[Z_W-1:0]);
        end
    end

    always_comb begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        if (start) begin
            busy_next  = 1'b1;
            phase_next = '0;
        end else if (busy_reg) begin
            if (phase_reg == PH_SAT) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                phase_next = phase_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ua_reg  <= a[Z_W-1] ? unsigned'(-a) : unsigned'(a);
            ub_reg  <= b[Z_W-1] ? unsigned'(-b) : unsigned'(b);
            neg_reg <= a[Z_W-1] ^ b[Z_W-1];
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (phase_reg <= PH_LAST_PROD) begin
                prod_reg     <= prod_w;
                prod_sel_reg <= phase_reg[1:0];
            end
            if (phase_reg >= PH_FIRST_ACC && phase_reg <= PH_LAST_ACC) begin
                acc_reg <= acc_reg + addend;
            end
            if (phase_reg == PH_ROUND) begin
                q_reg <= acc_reg[P_W-1:FRAC_BITS] + Q_W'(round_up);
            end
            if (phase_reg == PH_SAT) begin
                y_reg <= sat_w;
            end
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule
`default_nettype wire

// ----- hdl/mb_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mb_datapath
// Point registers, iteration arithmetic, periodicity snapshot, wide extra
// steps through the shared multiplier, and the result register.
// ----------------------------------------------------------------------------
module mb_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mb_pkg::dp_cmd_t                     cmd,
    output mb_pkg::dp_sts_t                     sts,
    input  logic signed [mb_pkg::C_W-1:0]       s_c_real,
    input  logic signed [mb_pkg::C_W-1:0]       s_c_imag,
    input  logic                                cfg_valid,
    input  logic [mb_pkg::ITER_BITS-1:0]        cfg_data,
    output logic [mb_pkg::ITER_BITS-1:0]        m_iteration_count,
    output logic [mb_pkg::EXT_W-1:0]            m_extended_count,
    output logic                                m_escaped,
    output logic [mb_pkg::MAG_W-1:0]            m_final_magnitude
);
    import mb_pkg::*;

    localparam int WIDE_W = Z_W + 2;
    localparam int ZX_W   = Z_W + 1;
    localparam logic [PER_W-1:0] PER_LAST = PER_W'(PERIOD_WINDOW - 1);

    function automatic logic signed [C_W-1:0] sat_c(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-C_W:0] top;
        top = v[WIDE_W-1:C_W-1];
        if ((&top) || !(|top)) begin
            return v[C_W-1:0];
        end
        return v[WIDE_W-1] ? {1'b1, {(C_W-1){1'b0}}} : {1'b0, {(C_W-1){1'b1}}};
    endfunction

    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [ZX_W-1:0] v);
        if (v[ZX_W-1] == v[Z_W-1]) begin
            return v[Z_W-1:0];
        end
        return v[ZX_W-1] ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}};
    endfunction

    logic [ITER_BITS-1:0]  max_iter_reg;

    logic signed [C_W-1:0] c_re_reg, c_im_reg;
    logic signed [Z_W-1:0] z_re_reg, z_im_reg;
    logic signed [C_W-1:0] snap_re_reg, snap_im_reg;
    logic [PER_W-1:0]      period_reg;
    logic [ITER_BITS-1:0]  count_reg;
    logic                  esc_reg;
    logic signed [Z_W-1:0] pr_rr_reg, pr_ii_reg, pr_ri_reg;
    logic signed [Z_W-1:0] t_re_reg, t_im_reg;
    logic [MAG_W-1:0]      mag_reg;

    logic [ITER_BITS-1:0]  out_count_reg;
    logic [EXT_W-1:0]      out_ext_reg;
    logic                  out_esc_reg;
    logic [MAG_W-1:0]      out_mag_reg;

    logic signed [C_W-1:0]    zr32, zi32;
    logic signed [Z_W-1:0]    m_rr, m_ii, m_ri;
    logic [ZX_W-1:0]          sq_sum;
    logic                     esc_w;
    logic signed [WIDE_W-1:0] re_acc, im_acc, re_shf, im_shf;
    logic signed [C_W-1:0]    new_re, new_im;
    logic                     periodic_w;
    logic [Z_W-1:0]           mag_abs, mag_shf;
    logic [MAG_W-1:0]         mag_w;

    logic signed [Z_W-1:0]    mul_a, mul_b, mul_y;
    logic                     mul_done;

    // main loop: z stays in 32-bit range, products exact
    assign zr32 = z_re_reg[C_W-1:0];
    assign zi32 = z_im_reg[C_W-1:0];
    assign m_rr = zr32 * zr32;
    assign m_ii = zi32 * zi32;
    assign m_ri = zr32 * zi32;

    assign sq_sum = {1'b0, pr_rr_reg} + {1'b0, pr_ii_reg};
    assign esc_w  = sq_sum > {1'b0, ESCAPE_LIMIT};

    // c folded in before the floor shift; 2*re*im uses one fraction bit less
    assign re_acc = WIDE_W'(pr_rr_reg) - WIDE_W'(pr_ii_reg)
                    + (WIDE_W'(c_re_reg) <<< FRAC_BITS);
    assign im_acc = WIDE_W'(pr_ri_reg) + (WIDE_W'(c_im_reg) <<< (FRAC_BITS - 1));
    assign re_shf = re_acc >>> FRAC_BITS;
    assign im_shf = im_acc >>> (FRAC_BITS - 1);
    assign new_re = sat_c(re_shf);
    assign new_im = sat_c(im_shf);

    assign periodic_w = (new_re == snap_re_reg) && (new_im == snap_im_reg);

    assign mag_abs = t_re_reg[Z_W-1] ? unsigned'(-t_re_reg) : unsigned'(t_re_reg);
    assign mag_shf = mag_abs >> (FRAC_BITS - MAG_FRAC);
    assign mag_w   = (|mag_shf[Z_W-1:MAG_W]) ? '1 : mag_shf[MAG_W-1:0];

    always_comb begin
        case (cmd.mul_sel)
            SEL_RR: begin
                mul_a = z_re_reg;
                mul_b = z_re_reg;
            end
            SEL_II: begin
                mul_a = z_im_reg;
                mul_b = z_im_reg;
            end
            SEL_RI: begin
                mul_a = z_re_reg;
                mul_b = z_im_reg;
            end
            default: begin
                mul_a = z_re_reg;
                mul_b = z_im_reg;
            end
        endcase
    end

    mb_mul64 u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .y       (mul_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= MAX_ITER_RESET;
        end else if (cfg_valid) begin
            max_iter_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                c_re_reg    <= s_c_real;
                c_im_reg    <= s_c_imag;
                z_re_reg    <= Z_W'(s_c_real);
                z_im_reg    <= Z_W'(s_c_imag);
                snap_re_reg <= '0;
                snap_im_reg <= '0;
                period_reg  <= PER_LAST;
                count_reg   <= '0;
                esc_reg     <= 1'b0;
            end
            OP_IT_MUL: begin
                pr_rr_reg <= m_rr;
                pr_ii_reg <= m_ii;
                pr_ri_reg <= m_ri;
            end
            OP_IT_UPD: begin
                if (esc_w) begin
                    esc_reg <= 1'b1;
                end else begin
                    z_re_reg <= Z_W'(new_re);
                    z_im_reg <= Z_W'(new_im);
                    if (periodic_w) begin
                        count_reg <= max_iter_reg;
                    end else begin
                        count_reg <= count_reg + 1'b1;
                        if (period_reg == PER_LAST) begin
                            period_reg  <= '0;
                            snap_re_reg <= new_re;
                            snap_im_reg <= new_im;
                        end else begin
                            period_reg <= period_reg + 1'b1;
                        end
                    end
                end
            end
            OP_X_SUM1: begin
                t_re_reg <= sat_z(ZX_W'(pr_rr_reg) - ZX_W'(pr_ii_reg));
                t_im_reg <= sat_z(ZX_W'(pr_ri_reg) + ZX_W'(pr_ri_reg));
            end
            OP_X_SUM2: begin
                z_re_reg <= sat_z(ZX_W'(t_re_reg) + ZX_W'(c_re_reg));
                z_im_reg <= sat_z(ZX_W'(t_im_reg) + ZX_W'(c_im_reg));
            end
            OP_M_SUM: begin
                t_re_reg <= sat_z(ZX_W'(z_re_reg) + ZX_W'(z_im_reg));
            end
            OP_M_MAG: begin
                mag_reg <= mag_w;
            end
            OP_OUT: begin
                out_count_reg <= count_reg;
                out_ext_reg   <= esc_reg ? EXT_W'(count_reg) + EXTRA_INC : EXT_W'(count_reg);
                out_esc_reg   <= esc_reg;
                out_mag_reg   <= esc_reg ? mag_reg : '0;
            end
            default: begin
            end
        endcase

        // wide products land in the main-loop product registers
        if (mul_done) begin
            case (cmd.mul_sel)
                SEL_RR:  pr_rr_reg <= mul_y;
                SEL_II:  pr_ii_reg <= mul_y;
                SEL_RI:  pr_ri_reg <= mul_y;
                default: pr_ri_reg <= mul_y;
            endcase
        end
    end

    always_comb begin
        sts.count_at_max = (count_reg == max_iter_reg);
        sts.escape       = esc_w;
        sts.periodic     = periodic_w;
        sts.mul_done     = mul_done;
    end

    assign m_iteration_count = out_count_reg;
    assign m_extended_count  = out_ext_reg;
    assign m_escaped         = out_esc_reg;
    assign m_final_magnitude = out_mag_reg;

endmodule
`default_nettype wire

// ----- hdl/mb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mb_ctrl
// Sequencer for one point: load, iterate (multiply / update), extra wide
// steps through the shared multiplier, magnitude, and result handoff.
// ----------------------------------------------------------------------------
module mb_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  mb_pkg::dp_sts_t  sts,
    output mb_pkg::dp_cmd_t  cmd
);
    import mb_pkg::*;

    localparam logic [XCNT_W-1:0] XCNT_LAST =
        XCNT_W'((EXTRA_STEPS > 0) ? EXTRA_STEPS - 1 : 0);

    ctrl_state_t        state_reg, state_next;
    mul_sel_t           sel_reg, sel_next;
    logic [XCNT_W-1:0]  xcnt_reg, xcnt_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;
    logic               out_load;

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_DONE) && out_free;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        xcnt_next  = xcnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_IT_MUL;
                end
            end
            ST_IT_MUL: begin
                state_next = sts.count_at_max ? ST_DONE : ST_IT_UPD;
            end
            ST_IT_UPD: begin
                if (sts.escape) begin
                    sel_next   = SEL_RR;
                    xcnt_next  = '0;
                    state_next = (EXTRA_STEPS > 0) ? ST_X_MUL : ST_M_SUM;
                end else if (sts.periodic) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_IT_MUL;
                end
            end
            ST_X_MUL: begin
                state_next = ST_X_WAIT;
            end
            ST_X_WAIT: begin
                if (sts.mul_done) begin
                    if (sel_reg == SEL_RI) begin
                        state_next = ST_X_SUM1;
                    end else begin
                        sel_next   = (sel_reg == SEL_RR) ? SEL_II : SEL_RI;
                        state_next = ST_X_MUL;
                    end
                end
            end
            ST_X_SUM1: begin
                state_next = ST_X_SUM2;
            end
            ST_X_SUM2: begin
                if (xcnt_reg == XCNT_LAST) begin
                    state_next = ST_M_SUM;
                end else begin
                    xcnt_next  = xcnt_reg + 1'b1;
                    sel_next   = SEL_RR;
                    state_next = ST_X_MUL;
                end
            end
            ST_M_SUM: begin
                state_next = ST_M_MAG;
            end
            ST_M_MAG: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_comb begin
        cmd.op        = OP_NONE;
        cmd.mul_start = 1'b0;
        cmd.mul_sel   = sel_reg;
        s_ready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.op  = s_valid ? OP_LOAD : OP_NONE;
            end
            ST_IT_MUL: begin
                cmd.op = sts.count_at_max ? OP_NONE : OP_IT_MUL;
            end
            ST_IT_UPD: begin
                cmd.op = OP_IT_UPD;
            end
            ST_X_MUL: begin
                cmd.mul_start = 1'b1;
            end
            ST_X_SUM1: begin
                cmd.op = OP_X_SUM1;
            end
            ST_X_SUM2: begin
                cmd.op = OP_X_SUM2;
            end
            ST_M_SUM: begin
                cmd.op = OP_M_SUM;
            end
            ST_M_MAG: begin
                cmd.op = OP_M_MAG;
            end
            ST_DONE: begin
                cmd.op = out_free ? OP_OUT : OP_NONE;
            end
            default: begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sel_reg     <= SEL_RR;
            xcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            xcnt_reg    <= xcnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

// ----- hdl/mb_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mb_checker
// Port-level checks on the escape-time block, bound to the top level.
// ----------------------------------------------------------------------------
module mb_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [mb_pkg::ITER_BITS-1:0]       m_iteration_count,
    input  logic [mb_pkg::EXT_W-1:0]           m_extended_count,
    input  logic                               m_escaped,
    input  logic [mb_pkg::MAG_W-1:0]           m_final_magnitude
);
    import mb_pkg::*;

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_iteration_count)
            && $stable(m_extended_count) && $stable(m_escaped)
            && $stable(m_final_magnitude))
        else $error("result changed while stalled");

    // one point in flight: busy right after taking a beat
    a_busy_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a point is in flight");

    a_no_escape_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_escaped |-> m_final_magnitude == '0
            && m_extended_count == EXT_W'(m_iteration_count))
        else $error("non-escaped result fields inconsistent");

    a_escape_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_escaped |-> m_extended_count == EXT_W'(m_iteration_count) + EXTRA_INC)
        else $error("extended count mismatch on escape");

endmodule

bind mandelbrot_escape_time mb_checker u_mb_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_iteration_count (m_iteration_count),
    .m_extended_count  (m_extended_count),
    .m_escaped         (m_escaped),
    .m_final_magnitude (m_final_magnitude)
);
`default_nettype wire

// ----- tb/tb_mandelbrot_escape_time.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time
// Self-checking bench for the escape-time point tester. A directed table
// covers the register extremes, the strict escape bound, periodic points and
// coordinate extremes. A random part follows, phase by phase under several
// iteration limits. Every result beat is checked against a typed result or
// an in-bench fixed-point model of the iteration. Sender bursts, receiver
// stalls and one long receiver hold-off exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB     = mb_pkg::FRAC_BITS;
    localparam int PW     = mb_pkg::PERIOD_WINDOW;
    localparam int XSTEPS = mb_pkg::EXTRA_STEPS;
    localparam int IW     = mb_pkg::ITER_BITS;
    localparam int EW     = mb_pkg::EXT_W;
    localparam int MW     = mb_pkg::MAG_W;
    localparam int CW     = mb_pkg::C_W;

    localparam logic [63:0] ESC_BOUND = 64'd4 << (2 * FB);
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = -S64_MAX - 64'sd1;

    localparam int RAND_PHASES    = 8;
    localparam int PHASE_POINTS   = 62;
    localparam int LONG_HOLD_AT   = 180;
    localparam int LONG_HOLD_LEN  = 600;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [IW-1:0] count;
        logic [EW-1:0] ext;
        logic          esc;
        logic [MW-1:0] mag;
    } escape_result_t;

    typedef struct packed {
        logic [IW-1:0]  limit;
        logic [CW-1:0]  cr;
        logic [CW-1:0]  ci;
        logic           typed;
        escape_result_t res;
    } point_row_t;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_valid  = 1'b0;
    logic          s_ready;
    logic [CW-1:0] s_c_real = '0;
    logic [CW-1:0] s_c_imag = '0;
    logic          m_valid;
    logic          m_ready  = 1'b0;
    logic [IW-1:0] m_iteration_count;
    logic [EW-1:0] m_extended_count;
    logic          m_escaped;
    logic [MW-1:0] m_final_magnitude;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [IW-1:0] cfg_data  = '0;

    escape_result_t pending_results [$];
    logic [IW-1:0]  limit_q;
    int unsigned    mismatches = 0;

    mandelbrot_escape_time i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_c_real          (s_c_real),
        .s_c_imag          (s_c_imag),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_iteration_count (m_iteration_count),
        .m_extended_count  (m_extended_count),
        .m_escaped         (m_escaped),
        .m_final_magnitude (m_final_magnitude),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- model

    function automatic longint clamp32(input longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic longint clamp64(input logic signed [127:0] v);
        logic signed [127:0] hi, lo;
        hi = S64_MAX;
        lo = S64_MIN;
        if (v > hi) return S64_MAX;
        if (v < lo) return S64_MIN;
        return v[63:0];
    endfunction

    // product back to FB fraction bits, floor rounding
    function automatic longint wide_mul(input longint a, input longint b);
        logic signed [127:0] wa, wb, pr;
        wa = a;
        wb = b;
        pr = (wa * wb) >>> FB;
        return clamp64(pr);
    endfunction

    function automatic longint wide_add(input longint a, input longint b);
        logic signed [127:0] s;
        s = a;
        s = s + b;
        return clamp64(s);
    endfunction

    function automatic longint wide_sub(input longint a, input longint b);
        logic signed [127:0] s;
        s = a;
        s = s - b;
        return clamp64(s);
    endfunction

    function automatic escape_result_t predict_escape(input logic [CW-1:0] cr_bits,
                                                      input logic [CW-1:0] ci_bits,
                                                      input logic [IW-1:0] lim);
        longint cr, ci, re, im, snap_re, snap_im, r2, i2, nre, nim, p;
        logic [63:0] mag2;
        logic signed [127:0] sw;
        int unsigned period, count, ext;
        bit esc, periodic;
        int k;
        escape_result_t r;
        cr = $signed(cr_bits);
        ci = $signed(ci_bits);
        re = cr;
        im = ci;
        snap_re = 0;
        snap_im = 0;
        period = PW - 1;
        count = 0;
        esc = 1'b0;
        periodic = 1'b0;
        r.mag = '0;
        while (count < lim) begin
            r2 = re * re;
            i2 = im * im;
            mag2 = r2 + i2;     // at most 2^63, bit pattern is the unsigned sum
            if (mag2 > ESC_BOUND) begin
                esc = 1'b1;
                break;
            end
            nim = clamp32(((re * im) >>> (FB - 1)) + ci);
            nre = clamp32(((r2 - i2) >>> FB) + cr);
            re = nre;
            im = nim;
            if (re == snap_re && im == snap_im) begin
                periodic = 1'b1;
                break;
            end
            period++;
            if (period > PW - 1) begin
                period = 0;
                snap_re = re;
                snap_im = im;
            end
            count++;
        end
        if (periodic) count = lim;
        ext = count;
        if (esc) begin
            for (k = 0; k < XSTEPS; k++) begin
                r2 = wide_mul(re, re);
                i2 = wide_mul(im, im);
                p  = wide_mul(re, im);
                im = wide_add(wide_add(p, p), ci);
                re = wide_add(wide_sub(r2, i2), cr);
                ext++;
            end
            sw = wide_add(re, im);
            if (sw < 0) sw = -sw;
            sw = sw >>> (FB - mb_pkg::MAG_FRAC);
            if (sw > 128'hFFFF_FFFF) r.mag = '1;
            else r.mag = sw[MW-1:0];
        end
        r.count = count[IW-1:0];
        r.ext   = ext[EW-1:0];
        r.esc   = esc;
        return r;
    endfunction

    // ------------------------------------------------------------- stimulus

    // expected result typed in only where obvious: zero limit or c = 0
    localparam int N_DIRECTED = 24;
    point_row_t directed_rows [N_DIRECTED] = '{
        '{16'd256,   32'h0000_0000, 32'h0000_0000, 1'b1, '{16'd256, 17'd256, 1'b0, 32'd0}},
        '{16'd256,   32'hE000_0000, 32'h0000_0000, 1'b0, '0},
        '{16'd256,   32'hF000_0000, 32'h0000_0000, 1'b0, '0},
        '{16'd256,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
        '{16'd256,   32'h8000_0000, 32'h8000_0000, 1'b0, '0},
        '{16'd256,   32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
        '{16'd256,   32'h2000_0000, 32'h0000_0000, 1'b0, '0},
        '{16'd256,   32'h0000_0000, 32'h2000_0000, 1'b0, '0},
        '{16'd256,   32'h2000_0001, 32'h0000_0000, 1'b0, '0},
        '{16'd256,   32'hF400_0000, 32'h0199_999A, 1'b0, '0},
        '{16'd256,   32'h0400_0000, 32'h0000_0000, 1'b0, '0},
        '{16'd256,   32'h04CC_CCCD, 32'h0000_0000, 1'b0, '0},
        '{16'd256,   32'h0000_0000, 32'hE000_0000, 1'b0, '0},
        '{16'd0,     32'h0000_0000, 32'h0000_0000, 1'b1, '{16'd0, 17'd0, 1'b0, 32'd0}},
        '{16'd0,     32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{16'd0, 17'd0, 1'b0, 32'd0}},
        '{16'd0,     32'hF400_0000, 32'h0199_999A, 1'b1, '{16'd0, 17'd0, 1'b0, 32'd0}},
        '{16'd1,     32'h0000_0000, 32'h0000_0000, 1'b1, '{16'd1, 17'd1, 1'b0, 32'd0}},
        '{16'd1,     32'h0800_0000, 32'h0000_0000, 1'b0, '0},
        '{16'd1,     32'h8000_0000, 32'h8000_0000, 1'b0, '0},
        '{16'd65535, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{16'd65535, 17'd65535, 1'b0, 32'd0}},
        '{16'd65535, 32'hE000_0000, 32'h0000_0000, 1'b0, '0},
        '{16'd65535, 32'hF000_0000, 32'h0000_0000, 1'b0, '0},
        '{16'd65535, 32'h1000_0000, 32'h1000_0000, 1'b0, '0},
        '{16'd65535, 32'h8000_0000, 32'h0000_0001, 1'b0, '0}
    };

    function automatic logic [CW-1:0] corner_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hE000_0000;
            4:       return 32'h2000_0000;
            5:       return 32'h0000_0001;
            6:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // mostly points near the set so the loop runs deep; the rest is noise
    function automatic void draw_point(output logic [CW-1:0] cr, output logic [CW-1:0] ci);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            cr = $urandom_range(0, 671088640) - 32'd536870912;    // -2.0 .. 0.5
            ci = $urandom_range(0, 671088640) - 32'd335544320;    // -1.25 .. 1.25
        end else if (pick < 55) begin
            cr = $urandom_range(0, 1342177280) - 32'd671088640;   // -2.5 .. 2.5
            ci = $urandom_range(0, 1342177280) - 32'd671088640;
        end else if (pick < 70) begin
            cr = $urandom;
            ci = $urandom;
        end else if (pick < 85) begin
            // coarse grid inside the set tends to lock into exact cycles
            cr = ($urandom_range(0, 20) - 32'd16) << 24;
            ci = ($urandom_range(0, 16) - 32'd8) << 24;
        end else begin
            cr = corner_value();
            ci = corner_value();
        end
    endfunction

    function automatic logic [IW-1:0] phase_limit(input int ph);
        case (ph)
            0:       return 16'd21;
            1:       return 16'd1;
            2:       return 16'd42;
            3:       return 16'd256;
            4:       return 16'd2;
            5:       return 16'd20;
            6:       return 16'($urandom_range(3, 64));
            default: return 16'd22;
        endcase
    endfunction

    task automatic send_point(input logic [CW-1:0] cr, input logic [CW-1:0] ci,
                              input bit typed, input escape_result_t typed_res);
        s_valid  <= 1'b1;
        s_c_real <= cr;
        s_c_imag <= ci;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (typed) pending_results = {pending_results, typed_res};
        else pending_results = {pending_results, predict_escape(cr, ci, limit_q)};
    endtask

    task automatic idle_sender(input int unsigned n);
        if (n != 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // wait until every result is back and the block has gone idle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [IW-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        limit_q = v;
    endtask

    initial begin
        logic [CW-1:0] cr, ci;
        int i, ph, sent, b, burst;
        aresetn <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        limit_q = mb_pkg::MAX_ITER_RESET;

        for (i = 0; i < N_DIRECTED; i++) begin
            if (directed_rows[i].limit != limit_q) begin
                drain_results();
                write_limit(directed_rows[i].limit);
            end
            send_point(directed_rows[i].cr, directed_rows[i].ci,
                       directed_rows[i].typed, directed_rows[i].res);
            idle_sender($urandom_range(0, 2));
        end

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            drain_results();
            write_limit(phase_limit(ph));
            sent = 0;
            while (sent < PHASE_POINTS) begin
                burst = $urandom_range(1, 16);
                for (b = 0; b < burst && sent < PHASE_POINTS; b++) begin
                    draw_point(cr, ci);
                    send_point(cr, ci, 1'b0, '0);
                    sent++;
                end
                idle_sender(($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(0, 6));
            end
        end

        drain_results();
        // catch any stray beat after the last expected one
        repeat (300) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_mandelbrot_escape_time: done, clean");
        end else begin
            $display("tb_mandelbrot_escape_time: done, errors");
        end
        $finish;
    end

    // ------------------------------------------------------ receiver, checks

    int unsigned beats_seen = 0;
    int unsigned seg_left   = 0;
    int unsigned hold_left  = 0;
    int unsigned ready_mode = 0;
    bit          long_hold_done = 1'b0;

    always @(posedge aclk) begin
        escape_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                beats_seen++;
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected: count %0d ext %0d esc %0d mag %0h",
                             $time, m_iteration_count, m_extended_count, m_escaped,
                             m_final_magnitude);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_iteration_count !== want.count) begin
                        $display("%0t: iteration_count expected %0d got %0d",
                                 $time, want.count, m_iteration_count);
                        mismatches++;
                    end
                    if (m_extended_count !== want.ext) begin
                        $display("%0t: extended_count expected %0d got %0d",
                                 $time, want.ext, m_extended_count);
                        mismatches++;
                    end
                    if (m_escaped !== want.esc) begin
                        $display("%0t: escaped expected %0d got %0d",
                                 $time, want.esc, m_escaped);
                        mismatches++;
                    end
                    if (m_final_magnitude !== want.mag) begin
                        $display("%0t: final_magnitude expected %0h got %0h",
                                 $time, want.mag, m_final_magnitude);
                        mismatches++;
                    end
                end
                if (beats_seen == LONG_HOLD_AT && !long_hold_done) begin
                    long_hold_done = 1'b1;
                    hold_left = LONG_HOLD_LEN;
                end
            end

            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left   = $urandom_range(20, 200);
                    ready_mode = $urandom_range(0, 3);
                end
                seg_left--;
                case (ready_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ((seg_left % 5) != 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int unsigned ticks;
        for (ticks = 0; ticks < CYCLE_LIMIT; ticks++) @(posedge aclk);
        $display("tb_mandelbrot_escape_time: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
